FILE: rtl/cit_pkg.sv
// Shared types and constants for the counted id table.
package cit_pkg;

  // Number of table slots.
  localparam int Depth = 16;
  // Id bits that take part in matching; must not exceed the 16-bit item_id port.
  localparam int IdBits = 16;
  localparam int CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef logic [Depth-1:0] slot_mask_t;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_REMOVE_ONE = 2'd1,
    CMD_REMOVE_ALL = 2'd2,
    CMD_CHECK      = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_ABSENT = 2'd2,
    STATUS_FULL   = 2'd3
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the word and the slot match results
    logic execute;  // apply the update and load the result register
  } ctrl_cmd_t;

endpackage

FILE: rtl/cit_datapath.sv
// Slot storage, associative match and update logic of the counted id table.
module cit_datapath import cit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            ctl,
  input  logic [1:0]           command,
  input  logic [15:0]          item_id,
  input  logic [15:0]          quantity,
  output logic [1:0]           status,
  output logic [CountBits-1:0] count_after
);

  slot_mask_t             slot_valid;
  slot_mask_t             slot_valid_next;
  logic [IdBits-1:0]      slot_id    [Depth];
  logic [CountBits-1:0]   slot_count [Depth];

  // captured word and match results
  command_t               cmd;
  logic [IdBits-1:0]      key;
  logic [CountBits-1:0]   qty;
  slot_mask_t             hit;
  slot_mask_t             free;
  logic                   any_valid;
  logic [CountBits-1:0]   hit_count;

  slot_mask_t             match;
  slot_mask_t             match_low;
  slot_mask_t             free_low;
  logic [CountBits-1:0]   sel_count;

  logic                   hit_any;
  logic                   free_any;
  slot_mask_t             target;
  logic                   set_valid;
  logic                   clr_valid;
  logic                   wr_count;
  logic                   wr_id;
  logic [CountBits-1:0]   new_count;
  status_t                status_next;
  logic [CountBits-1:0]   count_next;

  // compare every slot against the incoming id
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match[i] = slot_valid[i] && (slot_id[i] == item_id[IdBits-1:0]);
    end
    match_low = match & (~match + slot_mask_t'(1));
    free_low  = ~slot_valid & (slot_valid + slot_mask_t'(1));
    sel_count = '0;
    for (int i = 0; i < Depth; i++) begin
      sel_count = sel_count | (match_low[i] ? slot_count[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit  <= '0;
      free <= '0;
    end else if (ctl.capture) begin
      hit  <= match_low;
      free <= free_low;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd       <= command_t'(command);
      key       <= item_id[IdBits-1:0];
      qty       <= quantity;
      any_valid <= |slot_valid;
      hit_count <= sel_count;
    end
  end

  assign hit_any  = |hit;
  assign free_any = |free;
  assign target   = hit_any ? hit : free;

  always_comb begin
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    wr_count    = 1'b0;
    wr_id       = 1'b0;
    new_count   = hit_count;
    status_next = STATUS_DONE;
    count_next  = '0;
    if (cmd == CMD_ADD) begin
      if (hit_any) begin
        new_count  = (hit_count == CountMax) ? hit_count : hit_count + CountBits'(1);
        wr_count   = 1'b1;
        count_next = new_count;
      end else if (free_any) begin
        new_count  = (qty == '0) ? CountBits'(1) : qty;
        wr_count   = 1'b1;
        wr_id      = 1'b1;
        set_valid  = 1'b1;
        count_next = new_count;
      end else begin
        status_next = STATUS_FULL;
      end
    end else if (!any_valid) begin
      status_next = STATUS_EMPTY;
    end else if (!hit_any) begin
      status_next = STATUS_ABSENT;
    end else begin
      case (cmd)
        CMD_REMOVE_ONE: begin
          if (hit_count <= CountBits'(1)) begin
            clr_valid = 1'b1;
          end else begin
            new_count  = hit_count - CountBits'(1);
            wr_count   = 1'b1;
            count_next = new_count;
          end
        end
        CMD_REMOVE_ALL: clr_valid = 1'b1;
        default:        count_next = hit_count;
      endcase
    end
    slot_valid_next = (slot_valid | (set_valid ? target : '0)) & ~(clr_valid ? target : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctl.execute) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      if (ctl.execute && target[i]) begin
        if (wr_count) begin
          slot_count[i] <= new_count;
        end
        if (wr_id) begin
          slot_id[i] <= key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status      <= status_next;
      count_after <= count_next;
    end
  end

  // at most one slot may ever hold a given id
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(hit))
    else $error("more than one slot matched the id");

  a_free_is_free: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |-> ((free & slot_valid) == '0))
    else $error("chosen free slot is occupied");

  a_remove_all_frees: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && cmd == CMD_REMOVE_ALL && hit_any) |=> ((slot_valid & $past(hit)) == '0))
    else $error("remove all left the slot valid");

endmodule

FILE: rtl/cit_ctrl.sv
// Command sequencer of the counted id table: accept, execute, result handshake.
module cit_ctrl import cit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ctrl_cmd_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign cmd_ready   = (state == S_IDLE);
  assign ctl.capture = cmd_valid && cmd_ready;
  // the update waits only while the previous result is still unclaimed
  assign ctl.execute = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctl.execute) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (ctl.execute) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_EXEC))
    else $error("result raised without an executed word");

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> (state == S_EXEC))
    else $error("accepted word not followed by the update cycle");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result word dropped before it was taken");

endmodule

FILE: rtl/counted_id_table.sv
// Counted id table: an associative table of item ids, each with a saturating count.
//
// Each command word (add, remove one, remove all, check) yields exactly one result
// word with a status and the id's count after the command. In the cycle a word is
// accepted, every slot is compared with the id in parallel and the hit slot, the
// lowest free slot and the hit count are registered; then, in the update cycle,
// the selected slot is updated and the result register is loaded. A new word is
// taken only after the previous one has been updated. The result sits in its own
// register, so the next word is accepted while a result still waits; the update
// cycle stalls only if the previous result has not yet been taken. cmd_ready is
// low in the update cycle. Only the low IdBits bits of item_id are matched. Add
// saturates the count at 65535 and stores a zero quantity as 1. The table is
// empty after reset with no clearing pass.
module counted_id_table import cit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [1:0]  command,
  input  logic [15:0] item_id,
  input  logic [15:0] quantity,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [15:0] count_after
);

  ctrl_cmd_t ctl;

  cit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl)
  );

  cit_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .command     (command),
    .item_id     (item_id),
    .quantity    (quantity),
    .status      (status),
    .count_after (count_after)
  );

endmodule

FILE: tb/sv/tb_counted_id_table.sv
// Self-checking testbench for counted_id_table: directed and random command words.

// Tracks table contents from accepted command words and checks every reply word.
class id_count_tracker;
  typedef struct {
    cit_pkg::status_t  status;
    logic [15:0]       count;
  } reply_t;

  bit          held[cit_pkg::Depth];
  logic [15:0] held_id[cit_pkg::Depth];
  logic [15:0] held_count[cit_pkg::Depth];
  reply_t      replies_due[$];
  int          errors;

  function new();
    foreach (held[i]) held[i] = 1'b0;
    errors = 0;
  endfunction

  // Apply one accepted command to the tracked table and queue its reply.
  function void take_command(cit_pkg::command_t cmd, logic [15:0] raw_id,
                             logic [15:0] qty);
    logic [15:0] id_mask;
    logic [15:0] id;
    int          hit;
    int          free_slot;
    bit          any_held;
    reply_t      r;
    id_mask = (cit_pkg::IdBits >= 16) ? 16'hFFFF : 16'((1 << cit_pkg::IdBits) - 1);
    id = raw_id & id_mask;
    hit = -1;
    free_slot = -1;
    any_held = 1'b0;
    for (int i = 0; i < cit_pkg::Depth; i++) begin
      if (held[i]) begin
        any_held = 1'b1;
        if (hit < 0 && held_id[i] == id) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    r.status = cit_pkg::STATUS_DONE;
    r.count = '0;
    if (cmd == cit_pkg::CMD_ADD) begin
      if (hit >= 0) begin
        if (held_count[hit] != cit_pkg::CountMax)
          held_count[hit] = held_count[hit] + 16'd1;
        r.count = held_count[hit];
      end else if (free_slot >= 0) begin
        held[free_slot] = 1'b1;
        held_id[free_slot] = id;
        held_count[free_slot] = (qty == '0) ? 16'd1 : qty;
        r.count = held_count[free_slot];
      end else begin
        r.status = cit_pkg::STATUS_FULL;
      end
    end else if (!any_held) begin
      r.status = cit_pkg::STATUS_EMPTY;
    end else if (hit < 0) begin
      r.status = cit_pkg::STATUS_ABSENT;
    end else begin
      case (cmd)
        cit_pkg::CMD_REMOVE_ONE: begin
          if (held_count[hit] <= 16'd1) begin
            held_count[hit] = '0;
            held[hit] = 1'b0;
          end else begin
            held_count[hit] = held_count[hit] - 16'd1;
            r.count = held_count[hit];
          end
        end
        cit_pkg::CMD_REMOVE_ALL: held[hit] = 1'b0;
        default: r.count = held_count[hit];
      endcase
    end
    replies_due.push_back(r);
  endfunction

  function void match_reply(cit_pkg::status_t st, logic [15:0] cnt);
    reply_t r;
    if (replies_due.size() == 0) begin
      $error("reply word with nothing outstanding: status %0d count_after %0d", st, cnt);
      errors++;
      return;
    end
    r = replies_due.pop_front();
    if (st !== r.status) begin
      $error("status: expected %0d, actual %0d", r.status, st);
      errors++;
    end
    if (cnt !== r.count) begin
      $error("count_after: expected %0d, actual %0d", r.count, cnt);
      errors++;
    end
  endfunction

  function int outstanding();
    return replies_due.size();
  endfunction
endclass

module tb_counted_id_table;
  import cit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;   // long receiver hold-off for the backpressure phase
  localparam int PhaseWords = 440;
  localparam int PressureWords = 80;
  localparam int PoolMax = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [1:0]  command = CMD_CHECK;
  logic [15:0] item_id = '0;
  logic [15:0] quantity = 16'd1;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] count_after;

  // Idle percentages per side, set by the stimulus phases.
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  // Long hold requests: the stimulus bumps the request count, the receiver owns the rest.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int cycles = 0;

  // Ids that random words draw from; a small pool keeps hits, fills and empties frequent.
  logic [15:0] id_pool[PoolMax];
  int          pool_size = PoolMax;

  id_count_tracker tracker = new();

  counted_id_table uut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .item_id     (item_id),
    .quantity    (quantity),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .count_after (count_after)
  );

  always #5 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Handshakes are sampled in the active region of the edge, so they see pre-edge values.
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready)
      tracker.take_command(command_t'(command), item_id, quantity);
    if (!rst && rsp_valid && rsp_ready)
      tracker.match_reply(status_t'(status), count_after);
  end

  // Receiver: random stalls, or a counted hold-off when one has been requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Offer one command word and wait for it to be taken. Valid is left high on return so
  // back-to-back words never see valid dropped and raised in the same step.
  task automatic send_word(command_t cmd, logic [15:0] id, logic [15:0] qty);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    command   <= cmd;
    item_id   <= id;
    quantity  <= qty;
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
  endtask

  task automatic refill_pool(int size);
    pool_size = size;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
  endtask

  // Mostly pool ids with small counts, so counts climb and drain through zero;
  // some words carry near-saturation, zero or fully random quantities.
  task automatic send_random_word();
    command_t    cmd;
    logic [15:0] id;
    logic [15:0] qty;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 40)      cmd = CMD_ADD;
    else if (pick < 65) cmd = CMD_REMOVE_ONE;
    else if (pick < 75) cmd = CMD_REMOVE_ALL;
    else                cmd = CMD_CHECK;
    if ($urandom_range(9) == 0) id = 16'($urandom);
    else                        id = id_pool[$urandom_range(pool_size - 1)];
    pick = $urandom_range(99);
    if (pick < 60)      qty = 16'($urandom_range(4, 1));
    else if (pick < 75) qty = 16'($urandom_range(65535, 65532));
    else if (pick < 80) qty = '0;
    else                qty = 16'($urandom);
    send_word(cmd, id, qty);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, zero quantity, decrement to free, saturation,
    // decrement that leaves a count, absent ids, fill to full and reuse of a freed slot.
    send_word(CMD_CHECK, 16'h0000, 16'd1);
    send_word(CMD_REMOVE_ONE, 16'hFFFF, 16'd1);
    send_word(CMD_REMOVE_ALL, 16'hFFFF, 16'hFFFF);
    send_word(CMD_ADD, 16'h0000, 16'h0000);
    send_word(CMD_REMOVE_ONE, 16'h0000, 16'd1);
    send_word(CMD_ADD, 16'hFFFF, 16'hFFFF);
    send_word(CMD_ADD, 16'hFFFF, 16'd1);
    send_word(CMD_CHECK, 16'hFFFF, 16'd1);
    send_word(CMD_ADD, 16'h1234, 16'd2);
    send_word(CMD_REMOVE_ONE, 16'h1234, 16'd1);
    send_word(CMD_CHECK, 16'h1234, 16'd1);
    send_word(CMD_CHECK, 16'h5555, 16'd1);
    send_word(CMD_REMOVE_ALL, 16'h5555, 16'd1);
    for (int k = 0; k < Depth - 2; k++)
      send_word(CMD_ADD, 16'hA000 + 16'(k), 16'(k + 1));
    send_word(CMD_ADD, 16'hBEEF, 16'd7);
    send_word(CMD_REMOVE_ALL, 16'hFFFF, 16'd1);
    send_word(CMD_ADD, 16'hBEEF, 16'd7);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
        default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
      endcase
      for (int w = 0; w < PhaseWords; w++) begin
        // New id mix now and then; small pools empty the table, large ones overflow it.
        if (w % 110 == 0) refill_pool($urandom_range(PoolMax, 4));
        send_random_word();
      end
    end

    // Backpressure: receiver holds off while the sender keeps offering at full rate.
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_requests++;
    for (int w = 0; w < PressureWords; w++) send_random_word();

    cmd_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
